[hw/rtl/rlpc_pkg.sv]
`timescale 1ns / 1ps

package rlpc_pkg;

  // Palette geometry
  localparam int PALETTE_DEPTH = 32;
  localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);
  localparam int IDX_W         = $clog2(PALETTE_DEPTH);

  // Level thresholds
  localparam logic [7:0] LVL_NODATA  = 8'd0;
  localparam logic [7:0] LVL_BLANK   = 8'd254;
  localparam logic [7:0] LVL_DIM     = 8'd255;
  localparam logic [7:0] LVL_RAMP_LO = 8'd80;
  localparam logic [7:0] LVL_RAMP_HI = 8'd155;

  // Division by the ramp width of 75 as multiply by ceil(2^22 / 75), shift by 22.
  // Exact for every ramp offset below 75 and every count up to 256.
  localparam int LVL_OFS_W   = 7;
  localparam int RECIP_W     = 16;
  localparam int RECIP_SHIFT = 22;
  localparam logic [RECIP_W-1:0] RECIP = 16'd55925;
  localparam int SCALE_W     = CNT_W + RECIP_W;
  localparam int PROD_W      = LVL_OFS_W + SCALE_W;
  localparam int QUO_W       = PROD_W - RECIP_SHIFT;

  // Operation codes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_LOAD  = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WATER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAND  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROAD  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LABEL = 2'd3;

  typedef struct packed {
    logic       operation;
    logic       row_start;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] level;
    logic [7:0] water_mask;
    logic [7:0] road_mask;
    logic [7:0] name_mask;
  } in_item_t;

  typedef struct packed {
    logic [7:0] overlay_red;
    logic [7:0] overlay_green;
    logic [7:0] overlay_blue;
    logic [7:0] plain_red;
    logic [7:0] plain_green;
    logic [7:0] plain_blue;
  } out_item_t;

  // Palette load command from the stage to the palette store
  typedef struct packed {
    logic        en;
    logic        row_start;
    logic [23:0] color;
  } pal_load_t;

  // Dim one channel by a quarter
  function automatic logic [7:0] dim_channel(input logic [7:0] c);
    return c - {2'b00, c[7:2]};
  endfunction

endpackage

[hw/rtl/radar_level_palette_colorizer_core.sv]
`timescale 1ns / 1ps

// Channel   Ports                               Beat
// -------   ---------------------------------   ---------------------------------
// in        in_valid  in_ready  in_data         one palette load or one pixel
// out       out_valid out_ready out_data        overlay and plain colour, pixels only
// cfg       cfg_we    cfg_index cfg_data        one 24-bit overlay colour register
//
// One beat enters a stage register, passes combinational work (palette read, scale
// multiply, mask select, dimming) and lands in the result register, one beat per cycle
// sustained while results are taken. A load commits to the palette as it leaves the
// stage and yields no result. Reset (rst_n, synchronous, active low) clears the palette
// count, the previous load colour and the overlay colours, not the palette entries.
// A stalled result holds the stage only under a pixel.

module radar_level_palette_colorizer_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  rlpc_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output rlpc_pkg::out_item_t                out_data,
  input  logic                               cfg_we,
  input  logic [rlpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [23:0]                        cfg_data
);

  // Overlay colour registers
  logic [23:0] water_r, land_r, road_r, label_r;

  // Stage and result registers
  logic                s_vld_r, s_vld_nxt;
  rlpc_pkg::in_item_t  s_r;
  logic                o_vld_r, o_vld_nxt;
  rlpc_pkg::out_item_t o_r;

  // Handshake control
  logic o_free;
  logic s_is_load;
  logic s_adv;
  logic in_acc;

  // Palette interface
  rlpc_pkg::pal_load_t          pal_wr;
  logic [rlpc_pkg::IDX_W-1:0]   rd_idx;
  logic [23:0]                  rd_color;
  logic [rlpc_pkg::CNT_W-1:0]   count;
  logic [rlpc_pkg::SCALE_W-1:0] scale;

  // Pixel datapath
  logic                          nodata;
  logic [rlpc_pkg::LVL_OFS_W-1:0] lvl_ofs;
  logic [rlpc_pkg::PROD_W-1:0]   prod;
  logic [rlpc_pkg::QUO_W-1:0]    quo;
  logic [rlpc_pkg::CNT_W-1:0]    cnt_m1;
  logic [rlpc_pkg::CNT_W-1:0]    idx_full;
  logic [23:0]                   ov_col, pl_col;
  rlpc_pkg::out_item_t           res;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      water_r <= '0;
      land_r  <= '0;
      road_r  <= '0;
      label_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rlpc_pkg::CFG_WATER: water_r <= cfg_data;
        rlpc_pkg::CFG_LAND:  land_r  <= cfg_data;
        rlpc_pkg::CFG_ROAD:  road_r  <= cfg_data;
        rlpc_pkg::CFG_LABEL: label_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the stage when it holds a load, or a pixel with room downstream
  always_comb begin
    o_free    = !o_vld_r || out_ready;
    s_is_load = (s_r.operation == rlpc_pkg::OP_LOAD);
    s_adv     = s_vld_r && (s_is_load || o_free);
    in_ready  = !s_vld_r || s_adv;
    in_acc    = in_valid && in_ready;

    s_vld_nxt = s_vld_r;
    if (in_acc) begin
      s_vld_nxt = 1'b1;
    end else if (s_adv) begin
      s_vld_nxt = 1'b0;
    end

    o_vld_nxt = o_vld_r;
    if (s_adv && !s_is_load) begin
      o_vld_nxt = 1'b1;
    end else if (out_ready) begin
      o_vld_nxt = 1'b0;
    end
  end

  // A load commits exactly once, as it leaves the stage
  assign pal_wr.en        = s_vld_r && s_is_load;
  assign pal_wr.row_start = s_r.row_start;
  assign pal_wr.color     = {s_r.red_in, s_r.green_in, s_r.blue_in};

  rlpc_palette u_palette (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (pal_wr),
    .rd_idx   (rd_idx),
    .rd_color (rd_color),
    .count    (count),
    .scale    (scale)
  );

  // Palette index: ramp from level 80 to 154 over the loaded entries
  always_comb begin
    nodata  = (s_r.level == rlpc_pkg::LVL_NODATA) || (s_r.level >= rlpc_pkg::LVL_BLANK);
    lvl_ofs = rlpc_pkg::LVL_OFS_W'(s_r.level - rlpc_pkg::LVL_RAMP_LO);
    prod    = rlpc_pkg::PROD_W'(lvl_ofs) * rlpc_pkg::PROD_W'(scale);
    quo     = prod[rlpc_pkg::PROD_W-1:rlpc_pkg::RECIP_SHIFT];
    cnt_m1  = count - rlpc_pkg::CNT_W'(1);

    if (s_r.level < rlpc_pkg::LVL_RAMP_LO) begin
      idx_full = '0;
    end else if (s_r.level >= rlpc_pkg::LVL_RAMP_HI) begin
      idx_full = cnt_m1;
    end else if (quo >= rlpc_pkg::QUO_W'(count)) begin
      idx_full = cnt_m1;
    end else begin
      idx_full = rlpc_pkg::CNT_W'(quo);
    end
    rd_idx = idx_full[rlpc_pkg::IDX_W-1:0];
  end

  // Colour select: masks for no-data levels, palette otherwise, black for an empty palette, dimmed at LVL_DIM
  always_comb begin
    if (nodata) begin
      pl_col = '0;
      if (s_r.name_mask != 8'd0) begin
        ov_col = label_r;
      end else if (s_r.road_mask != 8'd0) begin
        ov_col = road_r;
      end else if (s_r.water_mask != 8'd0) begin
        ov_col = land_r;
      end else begin
        ov_col = water_r;
      end
    end else if (count == '0) begin
      pl_col = '0;
      ov_col = '0;
    end else begin
      pl_col = rd_color;
      ov_col = rd_color;
    end

    res.plain_red   = pl_col[23:16];
    res.plain_green = pl_col[15:8];
    res.plain_blue  = pl_col[7:0];
    if (s_r.level == rlpc_pkg::LVL_DIM) begin
      res.overlay_red   = rlpc_pkg::dim_channel(ov_col[23:16]);
      res.overlay_green = rlpc_pkg::dim_channel(ov_col[15:8]);
      res.overlay_blue  = rlpc_pkg::dim_channel(ov_col[7:0]);
    end else begin
      res.overlay_red   = ov_col[23:16];
      res.overlay_green = ov_col[15:8];
      res.overlay_blue  = ov_col[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else begin
      s_vld_r <= s_vld_nxt;
      o_vld_r <= o_vld_nxt;
    end
  end

  // Payload registers: stage captures on accept, result on a pixel advancing, hold otherwise
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s_r <= in_data;
    end
    if (s_adv && !s_is_load) begin
      o_r <= res;
    end
  end

  assign out_valid = o_vld_r;
  assign out_data  = o_r;

`ifndef SYNTHESIS
  // A pixel waiting on a stalled result must block the input
  a_pixel_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    s_vld_r && !s_is_load && o_vld_r && !out_ready |-> !in_ready)
    else $error("input accepted while a pixel is held behind a stalled result");

  // A load never raises a result
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    s_vld_r && s_is_load && !(o_vld_r && !out_ready) |=> !out_valid)
    else $error("load produced a result beat");

  // Palette count stays within the store
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count <= rlpc_pkg::CNT_W'(rlpc_pkg::PALETTE_DEPTH))
    else $error("palette count beyond depth");

  // Index stays below the count whenever a ramp level reads the palette
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s_vld_r && !s_is_load && !nodata && (count != '0) |-> idx_full < count)
    else $error("palette index beyond loaded entries");
`endif

endmodule

[hw/rtl/rlpc_palette.sv]
`timescale 1ns / 1ps

module rlpc_palette (
  input  logic                               clk,
  input  logic                               rst_n,
  input  rlpc_pkg::pal_load_t                wr,
  input  logic [rlpc_pkg::IDX_W-1:0]         rd_idx,
  output logic [23:0]                        rd_color,
  output logic [rlpc_pkg::CNT_W-1:0]         count,
  output logic [rlpc_pkg::SCALE_W-1:0]       scale
);

  logic [23:0]                  pal_r [rlpc_pkg::PALETTE_DEPTH];
  logic [rlpc_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [rlpc_pkg::SCALE_W-1:0] scale_r, scale_nxt;
  logic [23:0]                  prev_r, prev_nxt;
  logic [rlpc_pkg::CNT_W-1:0]   wr_pos;
  logic                         append;
  logic                         do_wr;

  always_comb begin
    wr_pos   = wr.row_start ? '0 : cnt_r;
    append   = wr.row_start || (wr.color != prev_r);
    do_wr    = wr.en && append && (wr_pos < rlpc_pkg::CNT_W'(rlpc_pkg::PALETTE_DEPTH));
    cnt_nxt  = cnt_r;
    prev_nxt = prev_r;
    if (wr.en) begin
      prev_nxt = wr.color;
      if (wr.row_start) begin
        cnt_nxt = '0;
      end
      if (do_wr) begin
        cnt_nxt = wr_pos + rlpc_pkg::CNT_W'(1);
      end
    end
    // Precompute count / 75 in fixed point so the pixel path has one multiply
    scale_nxt = rlpc_pkg::SCALE_W'(cnt_nxt) * rlpc_pkg::SCALE_W'(rlpc_pkg::RECIP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      scale_r <= '0;
      prev_r  <= '0;
    end else begin
      cnt_r   <= cnt_nxt;
      scale_r <= scale_nxt;
      prev_r  <= prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      pal_r[wr_pos[rlpc_pkg::IDX_W-1:0]] <= wr.color;
    end
  end

  assign rd_color = pal_r[rd_idx];
  assign count    = cnt_r;
  assign scale    = scale_r;

endmodule

[tb/tb_radar_level_palette_colorizer_core.sv]
`timescale 1ns / 1ps

// Checks the palette colourizer beat by beat: a software copy of the palette and the
// overlay registers predicts every pixel result, a monitor compares each delivered
// result with the oldest prediction, and both channels idle in random bursts.
module tb_radar_level_palette_colorizer_core;

  localparam int RANDOM_BEATS = 1390;  // beats in the random part, on top of directed ones
  localparam int QUIET_LIMIT  = 2000;  // cycles without any transfer before giving up
  localparam int SETTLE_WAIT  = 4;     // stage and result registers plus margin

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  rlpc_pkg::in_item_t   in_data;
  logic                 out_valid;
  logic                 out_ready;
  rlpc_pkg::out_item_t  out_data;
  logic                 cfg_we;
  logic [rlpc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [23:0]          cfg_data;

  // Predictor state: palette contents, fill count, last loaded colour, overlay colours
  logic [23:0] palette_model [rlpc_pkg::PALETTE_DEPTH];
  int          palette_count;
  logic [23:0] last_load_colour;
  logic [23:0] overlay_colour [4];

  rlpc_pkg::out_item_t pending_pixels [$];   // predicted pixel results, oldest first
  int          mismatches;
  int          quiet_cycles;
  int          gap_pct;              // chance of an input gap before a beat, in percent
  int          stall_pct;            // chance of an output stall per cycle, in percent

  radar_level_palette_colorizer_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] quarter_dim(input logic [7:0] c);
    return c - c / 8'd4;
  endfunction

  // Work out the result of one pixel beat from the current palette and overlays.
  function automatic rlpc_pkg::out_item_t colourise(input rlpc_pkg::in_item_t b);
    logic [23:0]         ov;
    logic [23:0]         pl;
    int                  lvl;
    int                  idx;
    rlpc_pkg::out_item_t res;
    ov  = '0;
    pl  = '0;
    lvl = b.level;
    if (b.level == rlpc_pkg::LVL_NODATA || b.level == rlpc_pkg::LVL_BLANK ||
        b.level == rlpc_pkg::LVL_DIM) begin
      // No-data levels: plain stays black, overlay follows the mask priority
      if (b.name_mask != 8'd0) ov = overlay_colour[rlpc_pkg::CFG_LABEL];
      else if (b.road_mask != 8'd0) ov = overlay_colour[rlpc_pkg::CFG_ROAD];
      else if (b.water_mask != 8'd0) ov = overlay_colour[rlpc_pkg::CFG_LAND];
      else ov = overlay_colour[rlpc_pkg::CFG_WATER];
    end else if (palette_count != 0) begin
      // Ramp: clamp below the low threshold and at or above the high one, scale between
      if (lvl < rlpc_pkg::LVL_RAMP_LO) idx = 0;
      else if (lvl >= rlpc_pkg::LVL_RAMP_HI) idx = palette_count - 1;
      else idx = (lvl - rlpc_pkg::LVL_RAMP_LO) * palette_count / 75;
      if (idx >= palette_count) idx = palette_count - 1;
      pl = palette_model[idx];
      ov = pl;
    end
    if (b.level == rlpc_pkg::LVL_DIM)
      ov = {quarter_dim(ov[23:16]), quarter_dim(ov[15:8]), quarter_dim(ov[7:0])};
    res.overlay_red   = ov[23:16];
    res.overlay_green = ov[15:8];
    res.overlay_blue  = ov[7:0];
    res.plain_red     = pl[23:16];
    res.plain_green   = pl[15:8];
    res.plain_blue    = pl[7:0];
    return res;
  endfunction

  // Advance the model by one accepted beat.
  task automatic model_beat(input rlpc_pkg::in_item_t b);
    logic [23:0] colour;
    colour = {b.red_in, b.green_in, b.blue_in};
    if (b.operation == rlpc_pkg::OP_LOAD) begin
      if (b.row_start) palette_count = 0;
      // A row start always appends; otherwise drop repeats of the last colour
      if ((b.row_start || colour != last_load_colour) &&
          palette_count < rlpc_pkg::PALETTE_DEPTH) begin
        palette_model[palette_count] = colour;
        palette_count++;
      end
      last_load_colour = colour;
    end else begin
      pending_pixels.push_back(colourise(b));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // A beat with every field random; callers overwrite what matters.
  function automatic rlpc_pkg::in_item_t random_beat();
    rlpc_pkg::in_item_t b;
    b.operation  = 1'($urandom_range(0, 1));
    b.row_start  = 1'($urandom_range(0, 1));
    b.red_in     = 8'($urandom_range(0, 255));
    b.green_in   = 8'($urandom_range(0, 255));
    b.blue_in    = 8'($urandom_range(0, 255));
    b.level      = 8'($urandom_range(0, 255));
    b.water_mask = 8'($urandom_range(0, 255));
    b.road_mask  = 8'($urandom_range(0, 255));
    b.name_mask  = 8'($urandom_range(0, 255));
    return b;
  endfunction

  // Present one beat at a falling edge, optionally after a gap, and hold it until taken.
  task automatic send_beat(input rlpc_pkg::in_item_t b);
    if ($urandom_range(0, 99) < gap_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    model_beat(b);
  endtask

  task automatic send_load(input logic row, input logic [23:0] colour);
    rlpc_pkg::in_item_t b;
    b = random_beat();
    b.operation = rlpc_pkg::OP_LOAD;
    b.row_start = row;
    {b.red_in, b.green_in, b.blue_in} = colour;
    send_beat(b);
  endtask

  task automatic send_pixel(input logic [7:0] lvl, input logic [7:0] wm, input logic [7:0] rm,
                            input logic [7:0] nm);
    rlpc_pkg::in_item_t b;
    b = random_beat();
    b.operation  = rlpc_pkg::OP_PIXEL;
    b.level      = lvl;
    b.water_mask = wm;
    b.road_mask  = rm;
    b.name_mask  = nm;
    send_beat(b);
  endtask

  // Drop valid, wait for every predicted result, then let loads drain out of the pipe.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_colour(input logic [rlpc_pkg::CFG_IDX_W-1:0] idx,
                              input logic [23:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    overlay_colour[idx] = value;
  endtask

  task automatic program_overlays(input logic [23:0] water, input logic [23:0] land,
                                  input logic [23:0] road, input logic [23:0] label);
    settle();
    write_colour(rlpc_pkg::CFG_WATER, water);
    write_colour(rlpc_pkg::CFG_LAND, land);
    write_colour(rlpc_pkg::CFG_ROAD, road);
    write_colour(rlpc_pkg::CFG_LABEL, label);
  endtask

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 5))
      0:       return rlpc_pkg::LVL_NODATA;
      1:       return ($urandom_range(0, 1) != 0) ? rlpc_pkg::LVL_BLANK : rlpc_pkg::LVL_DIM;
      2, 3:    return 8'($urandom_range(rlpc_pkg::LVL_RAMP_LO, rlpc_pkg::LVL_RAMP_HI - 1));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_mask();
    return ($urandom_range(0, 1) != 0) ? 8'h00 : 8'($urandom_range(0, 255));
  endfunction

  function automatic int pick_rate();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 6;
      default: return 30;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Out of reset: empty palette, zero overlays, and a first load that repeats the
  // reset value of the last colour is dropped.
  task automatic test_reset_state();
    send_pixel(8'd1, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(rlpc_pkg::LVL_NODATA, 8'hFF, 8'h00, 8'h00);
    send_load(1'b0, 24'h000000);
    send_pixel(8'd200, 8'h00, 8'h00, 8'h00);
    send_load(1'b0, 24'h123456);
    send_pixel(8'd128, 8'h00, 8'h00, 8'h00);
  endtask

  // Mask priority on the no-data levels, dimming on the top level.
  task automatic test_overlay_priority();
    program_overlays(24'h000000, 24'h00FF00, 24'hA5C3E1, 24'hFFFFFF);
    send_pixel(rlpc_pkg::LVL_BLANK, 8'h00, 8'h00, 8'h00);
    send_pixel(rlpc_pkg::LVL_NODATA, 8'h01, 8'h00, 8'h00);
    send_pixel(rlpc_pkg::LVL_DIM, 8'hFF, 8'h80, 8'h00);
    send_pixel(rlpc_pkg::LVL_DIM, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(rlpc_pkg::LVL_BLANK, 8'h00, 8'h00, 8'h01);
  endtask

  // A row start appends even a repeated colour; a plain repeat is dropped; then walk
  // the ramp edges.
  task automatic test_palette_ramp();
    send_load(1'b1, 24'h123456);
    send_load(1'b0, 24'h123456);
    send_load(1'b0, 24'hFFFFFF);
    send_load(1'b0, 24'h000000);
    send_load(1'b0, 24'hFFFFFF);
    send_pixel(8'd1, pick_mask(), pick_mask(), pick_mask());
    send_pixel(rlpc_pkg::LVL_RAMP_LO - 8'd1, pick_mask(), pick_mask(), pick_mask());
    send_pixel(rlpc_pkg::LVL_RAMP_LO, pick_mask(), pick_mask(), pick_mask());
    send_pixel(8'd117, pick_mask(), pick_mask(), pick_mask());
    send_pixel(rlpc_pkg::LVL_RAMP_HI - 8'd1, pick_mask(), pick_mask(), pick_mask());
    send_pixel(rlpc_pkg::LVL_RAMP_HI, pick_mask(), pick_mask(), pick_mask());
    send_pixel(8'd253, pick_mask(), pick_mask(), pick_mask());
  endtask

  // Overfill the palette: loads past the depth are dropped, the top entry holds.
  task automatic test_palette_full();
    logic [23:0] colour;
    colour = 24'($urandom);
    send_load(1'b1, colour);
    repeat (rlpc_pkg::PALETTE_DEPTH + 3) begin
      colour = colour ^ 24'($urandom_range(1, 24'hFFFFFF));
      send_load(1'b0, colour);
    end
    send_pixel(rlpc_pkg::LVL_RAMP_HI, 8'h00, 8'h00, 8'h00);
    send_pixel(rlpc_pkg::LVL_RAMP_HI - 8'd1, 8'h00, 8'h00, 8'h00);
    send_pixel(rlpc_pkg::LVL_RAMP_LO, 8'h00, 8'h00, 8'h00);
  endtask

  // Rows of loads followed by runs of pixels, with repeats, stray loads, rows without
  // a row start, and overlay changes between phases.
  task automatic test_random_rows();
    int          beats;
    int          since_cfg;
    int          phase;
    int          n_loads;
    int          n_pixels;
    logic [23:0] colour;
    beats     = 0;
    since_cfg = 0;
    phase     = 0;
    while (beats < RANDOM_BEATS) begin
      // Reprogram only outside the closing stretch, which stays free of idling
      if (since_cfg >= 300 && beats < RANDOM_BEATS - 200) begin
        phase++;
        case (phase % 3)
          0:       program_overlays(24'h000000, 24'h000000, 24'h000000, 24'h000000);
          1:       program_overlays(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
          default: program_overlays(24'($urandom), 24'($urandom), 24'($urandom),
                                    24'($urandom));
        endcase
        since_cfg = 0;
      end
      // Hold both sides busy for the closing stretch
      if (beats >= RANDOM_BEATS - 200) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else if ($urandom_range(0, 3) == 0) begin
        gap_pct   = pick_rate();
        stall_pct = pick_rate();
      end
      case ($urandom_range(0, 7))
        0:       n_loads = $urandom_range(8, 31);
        1:       n_loads = $urandom_range(30, rlpc_pkg::PALETTE_DEPTH + 8);
        default: n_loads = $urandom_range(0, 8);
      endcase
      n_pixels = $urandom_range(1, 12);
      colour   = 24'($urandom);
      // Most rows open with a row start; the rest keep extending the old palette
      if ($urandom_range(0, 9) != 0) begin
        send_load(1'b1, colour);
        beats++;
      end
      repeat (n_loads) begin
        case ($urandom_range(0, 7))
          0, 1:    ;                               // repeat the last colour
          2:       colour = 24'h000000;
          default: colour = 24'($urandom);
        endcase
        send_load(1'b0, colour);
        beats++;
      end
      repeat (n_pixels) begin
        if ($urandom_range(0, 19) == 0) begin
          send_load(1'($urandom_range(0, 1)), 24'($urandom));
          beats++;
        end
        send_pixel(pick_level(), pick_mask(), pick_mask(), pick_mask());
        beats++;
      end
      since_cfg += n_loads + n_pixels;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Compare each delivered beat with the oldest prediction.
  always @(posedge clk) begin
    rlpc_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $error("result beat with no pixel outstanding: %h", out_data);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("overlay_red", want.overlay_red, out_data.overlay_red);
        check_field("overlay_green", want.overlay_green, out_data.overlay_green);
        check_field("overlay_blue", want.overlay_blue, out_data.overlay_blue);
        check_field("plain_red", want.plain_red, out_data.plain_red);
        check_field("plain_green", want.plain_green, out_data.plain_green);
        check_field("plain_blue", want.plain_blue, out_data.plain_blue);
      end
    end
  end

  // Watchdog: give up once nothing has moved on any port for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("radar_level_palette_colorizer_core: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result back-pressure: random stall bursts, none while stall_pct is zero.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst_n && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_data          = '0;
    cfg_we           = 1'b0;
    cfg_index        = rlpc_pkg::CFG_WATER;
    cfg_data         = '0;
    palette_count    = 0;
    last_load_colour = '0;
    mismatches       = 0;
    quiet_cycles     = 0;
    gap_pct          = 10;
    stall_pct        = 10;
    foreach (overlay_colour[i]) overlay_colour[i] = '0;
    foreach (palette_model[i]) palette_model[i] = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_overlay_priority();
    test_palette_ramp();
    test_palette_full();
    test_random_rows();

    // Drain: wait for the last pixel, then give the pipe time to show any stray beat
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("radar_level_palette_colorizer_core: match");
    end else begin
      $display("radar_level_palette_colorizer_core: mismatch");
    end
    $finish;
  end

endmodule
